FILE: rtl/core/pza_pkg.sv
// Shared types and constants for the priority zone allocator.
// Holds request codes, slot status codes, the result beat and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pza_pkg;

    // Default sizes handed down by the top level
    localparam int MAX_ENTRIES_DEF = 32;
    localparam int NUM_ZONES_DEF   = 32;

    // Fixed field widths of the request and result beats
    localparam int TYPE_W = 3;
    localparam int ID_W   = 8;
    localparam int PRI_W  = 8;
    localparam int MASK_W = 32;

    // Request codes; the two unused codes are ignored
    typedef enum logic [TYPE_W-1:0] {
        REQ_REGISTER   = 3'd0,
        REQ_ACTIVATE   = 3'd1,
        REQ_DEACTIVATE = 3'd2,
        REQ_FRAME      = 3'd3,
        REQ_QUERY      = 3'd4,
        REQ_CLEAR      = 3'd5
    } req_kind_t;

    // Slot status codes
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_ACTIVE = 2'd1,
        ST_SHADOW = 2'd2
    } slot_status_t;

    // One result beat
    typedef struct packed {
        logic              entry_valid;
        logic [ID_W-1:0]   out_id;
        logic [PRI_W-1:0]  out_priority;
        logic              out_status;
        logic [MASK_W-1:0] granted_mask;
        logic              rendered;
        logic              last;
    } rsp_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;      // latch the request beat, rewind index and occupancy
        logic clear_cnt;   // empty the table
        logic reg_init;    // load index with the entry count
        logic idx_inc;
        logic idx_dec;
        logic rd_cur;      // read the slot at index
        logic rd_prev;     // read the slot below index
        logic wr_shift;    // write the read slot back one place up
        logic wr_new;      // write the new entry at index, bump the count
        logic upd_status;  // apply activate or deactivate to the read slot
        logic walk_eval;   // grant and list the read slot
        logic flush;       // emit the final beat of a listing
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic idx_end;     // index reached the entry count
        logic idx_zero;
        logic full;
        logic pri_gt;      // new priority beats the read slot
        logic id_match;    // read slot carries the requested id
        logic out_free;    // output register can take a beat this cycle
    } stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/pza_ifs.sv
// Request and result channel interfaces for the priority zone allocator.
// Valid/ready handshake with the payload fields alongside; uses pza_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pza_req_if;
    import pza_pkg::*;

    logic              valid;
    logic              ready;
    logic [TYPE_W-1:0] req_type;
    logic [ID_W-1:0]   effect_id;
    logic [PRI_W-1:0]  priority_req;
    logic [MASK_W-1:0] zone_mask;

    modport source (output valid, output req_type, output effect_id,
                    output priority_req, output zone_mask, input ready);
    modport sink   (input valid, input req_type, input effect_id,
                    input priority_req, input zone_mask, output ready);
endinterface

interface pza_rsp_if;
    import pza_pkg::*;

    logic              valid;
    logic              ready;
    logic              entry_valid;
    logic [ID_W-1:0]   out_id;
    logic [PRI_W-1:0]  out_priority;
    logic              out_status;
    logic [MASK_W-1:0] granted_mask;
    logic              rendered;
    logic              last;

    modport source (output valid, output entry_valid, output out_id,
                    output out_priority, output out_status, output granted_mask,
                    output rendered, output last, input ready);
    modport sink   (input valid, input entry_valid, input out_id,
                    input out_priority, input out_status, input granted_mask,
                    input rendered, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pza_dpath.sv
// Datapath of the priority zone allocator: slot memory, request latch,
// count/index/occupancy registers, pending listing beat and output register.
// Driven by pza_ctrl through pza_pkg::cmd_t; uses pza_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pza_dpath #(
    parameter int MAX_ENTRIES = pza_pkg::MAX_ENTRIES_DEF,
    parameter int NUM_ZONES   = pza_pkg::NUM_ZONES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pza_pkg::cmd_t               cmd,
    output pza_pkg::stat_t              stat,
    input  logic [pza_pkg::TYPE_W-1:0]  req_type,
    input  logic [pza_pkg::ID_W-1:0]    effect_id,
    input  logic [pza_pkg::PRI_W-1:0]   priority_req,
    input  logic [pza_pkg::MASK_W-1:0]  zone_mask,
    input  logic                        rsp_ready,
    output logic                        rsp_valid,
    output pza_pkg::rsp_t               rsp_data
);
    import pza_pkg::*;

    localparam int ZW    = (NUM_ZONES < MASK_W) ? NUM_ZONES : MASK_W;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] prio;
        logic [ZW-1:0]    zones;
        slot_status_t     status;
    } entry_t;

    entry_t            mem [MAX_ENTRIES];
    entry_t            rd_reg;

    logic [TYPE_W-1:0] kind_reg;
    logic [ID_W-1:0]   id_reg;
    logic [PRI_W-1:0]  pri_reg;
    logic [ZW-1:0]     zm_reg;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  idx_prev;
    logic [ZW-1:0]     occ_reg, occ_next;
    logic              pend_valid_reg, pend_valid_next;
    rsp_t              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg, out_next;

    logic              is_frame;
    logic              rd_active;
    logic [ZW-1:0]     grant;
    logic              grant_any;
    slot_status_t      walk_status;
    slot_status_t      list_status;
    rsp_t              listed;
    slot_status_t      find_status;
    logic              find_wr;
    logic              wr_en;
    entry_t            wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              out_free;

    // Grant and listing for the slot just read
    always_comb
    begin
        is_frame    = (kind_reg == REQ_FRAME);
        rd_active   = (rd_reg.status != ST_IDLE);
        grant       = rd_reg.zones & ~occ_reg;
        grant_any   = |grant;
        if (grant_any)
            walk_status = ST_ACTIVE;
        else if (rd_reg.status == ST_ACTIVE)
            walk_status = ST_SHADOW;
        else
            walk_status = rd_reg.status;
        list_status = is_frame ? walk_status : rd_reg.status;

        listed.entry_valid  = 1'b1;
        listed.out_id       = rd_reg.id;
        listed.out_priority = rd_reg.prio;
        listed.out_status   = (list_status == ST_SHADOW);
        listed.granted_mask = is_frame ? MASK_W'(grant) : MASK_W'(rd_reg.zones);
        listed.rendered     = is_frame & grant_any;
        listed.last         = 1'b0;
    end

    // Activate and deactivate act only from the right status
    always_comb
    begin
        find_status = rd_reg.status;
        find_wr     = 1'b0;
        if (kind_reg == REQ_ACTIVATE && rd_reg.status == ST_IDLE)
        begin
            find_status = ST_ACTIVE;
            find_wr     = 1'b1;
        end
        else if (kind_reg == REQ_DEACTIVATE && rd_reg.status != ST_IDLE)
        begin
            find_status = ST_IDLE;
            find_wr     = 1'b1;
        end
    end

    // Select the memory write
    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = rd_reg;
        if (cmd.wr_new)
        begin
            wr_en         = 1'b1;
            wr_data.id    = id_reg;
            wr_data.prio  = pri_reg;
            wr_data.zones = zm_reg;
            wr_data.status = ST_IDLE;
        end
        else if (cmd.wr_shift)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.upd_status && find_wr)
        begin
            wr_en          = 1'b1;
            wr_data.status = find_status;
        end
        else if (cmd.walk_eval && is_frame && rd_active)
        begin
            wr_en          = 1'b1;
            wr_data.status = walk_status;
        end
    end

    assign idx_prev = idx_reg - CNT_W'(1);
    assign rd_en    = cmd.rd_cur | cmd.rd_prev;
    assign rd_addr  = cmd.rd_prev ? idx_prev[IDX_W-1:0] : idx_reg[IDX_W-1:0];

    // Slot memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[idx_reg[IDX_W-1:0]] <= wr_data;
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    // Latch the request beat
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg <= req_type;
            id_reg   <= effect_id;
            pri_reg  <= priority_req;
            zm_reg   <= zone_mask[ZW-1:0];
        end
    end

    assign out_free = !out_valid_reg || rsp_ready;

    // Next values of count, index, occupancy and the result registers
    always_comb
    begin
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        occ_next        = occ_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_next        = out_reg;

        if (cmd.clear_cnt)
            cnt_next = '0;
        else if (cmd.wr_new)
            cnt_next = cnt_reg + CNT_W'(1);

        if (cmd.accept)
            idx_next = '0;
        else if (cmd.reg_init)
            idx_next = cnt_reg;
        else if (cmd.idx_inc)
            idx_next = idx_reg + CNT_W'(1);
        else if (cmd.idx_dec)
            idx_next = idx_prev;

        if (cmd.accept)
            occ_next = '0;
        else if (cmd.walk_eval && is_frame && rd_active)
            occ_next = occ_reg | grant;

        // Hold one listed beat back so the final one can carry last
        if (cmd.walk_eval && rd_active)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
            end
            pend_next       = listed;
            pend_valid_next = 1'b1;
        end

        if (cmd.flush)
        begin
            out_valid_next = 1'b1;
            if (pend_valid_reg)
            begin
                out_next      = pend_reg;
                out_next.last = 1'b1;
            end
            else
            begin
                out_next      = '0;
                out_next.last = 1'b1;
            end
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            idx_reg        <= '0;
            occ_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            occ_reg        <= occ_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payloads need no reset
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // Report status to the controller
    always_comb
    begin
        stat.idx_end  = (idx_reg == cnt_reg);
        stat.idx_zero = (idx_reg == '0);
        stat.full     = (cnt_reg == CNT_W'(MAX_ENTRIES));
        stat.pri_gt   = (pri_reg > rd_reg.prio);
        stat.id_match = (rd_reg.id == id_reg);
        stat.out_free = out_free;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pza_ctrl.sv
// Controller of the priority zone allocator: sequences insert, id search
// and table walks over the datapath; uses pza_pkg command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module pza_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  logic [pza_pkg::TYPE_W-1:0] req_type,
    output logic                       req_ready,
    input  pza_pkg::stat_t             stat,
    output pza_pkg::cmd_t              cmd
);
    import pza_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REG_INIT,
        S_REG_CHECK,
        S_REG_EVAL,
        S_FIND_READ,
        S_FIND_EVAL,
        S_WALK_READ,
        S_WALK_EVAL,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;

    assign req_ready = (state_reg == S_IDLE);

    // Decode commands and the next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (req_type == REQ_REGISTER)
                        state_next = S_REG_INIT;
                    else if (req_type inside {REQ_ACTIVATE, REQ_DEACTIVATE})
                        state_next = S_FIND_READ;
                    else if (req_type inside {REQ_FRAME, REQ_QUERY})
                        state_next = S_WALK_READ;
                    else if (req_type == REQ_CLEAR)
                        cmd.clear_cnt = 1'b1;
                end
            end
            // Drop the insert when the table is full
            S_REG_INIT:
            begin
                if (stat.full)
                    state_next = S_IDLE;
                else
                begin
                    cmd.reg_init = 1'b1;
                    state_next   = S_REG_CHECK;
                end
            end
            S_REG_CHECK:
            begin
                if (stat.idx_zero)
                begin
                    cmd.wr_new = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_REG_EVAL;
                end
            end
            // Shift lower-priority slots up until the insert point
            S_REG_EVAL:
            begin
                if (stat.pri_gt)
                begin
                    cmd.wr_shift = 1'b1;
                    cmd.idx_dec  = 1'b1;
                    state_next   = S_REG_CHECK;
                end
                else
                begin
                    cmd.wr_new = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FIND_READ:
            begin
                if (stat.idx_end)
                    state_next = S_IDLE;
                else
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_FIND_EVAL;
                end
            end
            // Stop at the first slot with a matching id
            S_FIND_EVAL:
            begin
                if (stat.id_match)
                begin
                    cmd.upd_status = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_FIND_READ;
                end
            end
            S_WALK_READ:
            begin
                if (stat.idx_end)
                    state_next = S_FLUSH;
                else
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_WALK_EVAL;
                end
            end
            // Hold while the output register is blocked
            S_WALK_EVAL:
            begin
                if (stat.out_free)
                begin
                    cmd.walk_eval = 1'b1;
                    cmd.idx_inc   = 1'b1;
                    state_next    = S_WALK_READ;
                end
            end
            S_FLUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/priority_zone_allocator.sv
// Top level of the priority zone allocator: joins pza_ctrl and pza_dpath
// to the request and result channels; uses pza_pkg and pza_ifs.
//
//   channel   dir   beat contents
//   req       in    req_type, effect_id, priority_req, zone_mask
//   rsp       out   entry_valid, out_id, out_priority, out_status, granted_mask, rendered, last
//
// Pace: one slot memory read port, so each slot is read in a read state and
// then evaluated in an eval state. Frame and query walk every table entry and
// then flush the closing beat; activate and deactivate search slots until the
// id matches or the table ends; register moves lower-priority slots up, and is
// dropped when the table is full; clear and unused codes finish in idle.
// Reset clears the entry count but not the slot memory, so no clearing
// pass runs. A stalled rsp beat holds the walk in place until the output
// register frees; req is taken only between requests.
`timescale 1ns / 1ps
`default_nettype none

module priority_zone_allocator #(
    parameter int MAX_ENTRIES = pza_pkg::MAX_ENTRIES_DEF,
    parameter int NUM_ZONES   = pza_pkg::NUM_ZONES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pza_req_if.sink   req,
    pza_rsp_if.source rsp
);
    import pza_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    rsp_t  rsp_data;

    pza_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pza_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .NUM_ZONES   (NUM_ZONES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (req.req_type),
        .effect_id    (req.effect_id),
        .priority_req (req.priority_req),
        .zone_mask    (req.zone_mask),
        .rsp_ready    (rsp.ready),
        .rsp_valid    (rsp.valid),
        .rsp_data     (rsp_data)
    );

    // Unpack the result beat onto the channel
    assign rsp.entry_valid  = rsp_data.entry_valid;
    assign rsp.out_id       = rsp_data.out_id;
    assign rsp.out_priority = rsp_data.out_priority;
    assign rsp.out_status   = rsp_data.out_status;
    assign rsp.granted_mask = rsp_data.granted_mask;
    assign rsp.rendered     = rsp_data.rendered;
    assign rsp.last         = rsp_data.last;

endmodule

`default_nettype wire

FILE: verif/pza_checker.sv
// Checker for the priority zone allocator: watches the request and result
// channels, keeps its own copy of the slot table and compares every result beat.
// Depends on pza_pkg and the channel interfaces in pza_ifs.
`timescale 1ns / 1ps

module pza_checker #(
    parameter int MAX_ENTRIES = pza_pkg::MAX_ENTRIES_DEF,
    parameter int NUM_ZONES   = pza_pkg::NUM_ZONES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    pza_req_if   req,
    pza_rsp_if   rsp,
    output int   fail_count,
    output int   beats_due
);
    import pza_pkg::*;

    localparam int                KEPT_ZONES = (NUM_ZONES < MASK_W) ? NUM_ZONES : MASK_W;
    localparam logic [MASK_W-1:0] ZONE_KEEP  = {MASK_W{1'b1}} >> (MASK_W - KEPT_ZONES);

    // Shadow copy of the slot table, kept sorted by descending priority
    logic [ID_W-1:0]   tab_id    [MAX_ENTRIES];
    logic [PRI_W-1:0]  tab_pri   [MAX_ENTRIES];
    logic [MASK_W-1:0] tab_zones [MAX_ENTRIES];
    slot_status_t      tab_state [MAX_ENTRIES];
    int                tab_count = 0;

    rsp_t due_listing [$];
    int   errors = 0;

    // Apply one request beat to the table and queue the listing it produces
    task automatic advance_table(input logic [TYPE_W-1:0] kind, input logic [ID_W-1:0] id,
                                 input logic [PRI_W-1:0] pri,
                                 input logic [MASK_W-1:0] zones);
        int                pos;
        int                hit;
        int                listed;
        logic [MASK_W-1:0] occupied;
        logic [MASK_W-1:0] grant;
        rsp_t              held;

        pos      = tab_count;
        hit      = -1;
        listed   = 0;
        occupied = '0;
        held     = '0;

        // First slot carrying the id; later duplicates are never touched
        for (int i = 0; i < tab_count; i++)
            if (hit < 0 && tab_id[i] == id)
                hit = i;

        case (kind)
            REQ_REGISTER:
            begin
                // Drop the request when the table is full
                if (tab_count < MAX_ENTRIES)
                begin
                    // Insert after every slot of equal or higher priority
                    for (int i = tab_count - 1; i >= 0; i--)
                        if (pri > tab_pri[i])
                            pos = i;
                    for (int i = tab_count; i > pos; i--)
                    begin
                        tab_id[i]    = tab_id[i-1];
                        tab_pri[i]   = tab_pri[i-1];
                        tab_zones[i] = tab_zones[i-1];
                        tab_state[i] = tab_state[i-1];
                    end
                    tab_id[pos]    = id;
                    tab_pri[pos]   = pri;
                    tab_zones[pos] = zones & ZONE_KEEP;
                    tab_state[pos] = ST_IDLE;
                    tab_count++;
                end
            end
            REQ_ACTIVATE:
            begin
                if (hit >= 0 && tab_state[hit] == ST_IDLE)
                    tab_state[hit] = ST_ACTIVE;
            end
            REQ_DEACTIVATE:
            begin
                if (hit >= 0 && tab_state[hit] != ST_IDLE)
                    tab_state[hit] = ST_IDLE;
            end
            REQ_FRAME, REQ_QUERY:
            begin
                for (int i = 0; i < tab_count; i++)
                begin
                    if (tab_state[i] != ST_IDLE)
                    begin
                        grant = tab_zones[i];
                        // Grant what is left; nothing left means shadowed
                        if (kind == REQ_FRAME)
                        begin
                            grant = tab_zones[i] & ~occupied;
                            if (grant != '0)
                            begin
                                tab_state[i] = ST_ACTIVE;
                                occupied     = occupied | grant;
                            end
                            else
                                tab_state[i] = ST_SHADOW;
                        end
                        if (listed != 0)
                            due_listing.push_back(held);
                        held              = '0;
                        held.entry_valid  = 1'b1;
                        held.out_id       = tab_id[i];
                        held.out_priority = tab_pri[i];
                        held.out_status   = (tab_state[i] == ST_SHADOW);
                        held.granted_mask = grant;
                        held.rendered     = (kind == REQ_FRAME) && (grant != '0);
                        listed++;
                    end
                end
                // Close the listing; with nothing listed this is the empty beat
                held.last = 1'b1;
                due_listing.push_back(held);
            end
            REQ_CLEAR:
                tab_count = 0;
            default:
                ;
        endcase
    endtask

    // Predict on request beats, compare on result beats
    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;

        if (!rst_n)
        begin
            tab_count = 0;
            due_listing.delete();
        end
        else
        begin
            if (req.valid && req.ready)
                advance_table(req.req_type, req.effect_id, req.priority_req, req.zone_mask);

            if (rsp.valid && rsp.ready)
            begin
                got.entry_valid  = rsp.entry_valid;
                got.out_id       = rsp.out_id;
                got.out_priority = rsp.out_priority;
                got.out_status   = rsp.out_status;
                got.granted_mask = rsp.granted_mask;
                got.rendered     = rsp.rendered;
                got.last         = rsp.last;

                if (due_listing.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: result beat with nothing due: valid=%0b id=%02h last=%0b",
                                 $time, got.entry_valid, got.out_id, got.last);
                    errors++;
                end
                else
                begin
                    want = due_listing.pop_front();
                    if (got !== want)
                    begin
                        if (errors < 10)
                        begin
                            $display("%0t: result beat mismatch", $time);
                            $display("  expected valid=%0b id=%02h pri=%02h st=%0b mask=%08h rend=%0b last=%0b",
                                     want.entry_valid, want.out_id, want.out_priority,
                                     want.out_status, want.granted_mask, want.rendered,
                                     want.last);
                            $display("  actual   valid=%0b id=%02h pri=%02h st=%0b mask=%08h rend=%0b last=%0b",
                                     got.entry_valid, got.out_id, got.out_priority,
                                     got.out_status, got.granted_mask, got.rendered,
                                     got.last);
                        end
                        errors++;
                    end
                end
            end
        end

        fail_count <= errors;
        beats_due  <= due_listing.size();
    end

endmodule

FILE: verif/priority_zone_allocator_tb.sv
// Testbench top for the priority zone allocator: clock, reset, request
// stimulus, result back-pressure, watchdog and verdict.
// Depends on pza_pkg, pza_ifs, the allocator RTL and pza_checker.
`timescale 1ns / 1ps

module priority_zone_allocator_tb;
    import pza_pkg::*;

    localparam int                ITEM_TARGET  = 410;
    localparam int                QUIET_LIMIT  = 3000;
    localparam int                TAIL_CYCLES  = 80;
    localparam logic [ID_W-1:0]   ID_POOL      = 8'h10;
    localparam logic [TYPE_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [TYPE_W-1:0] REQ_SPARE_HI = 3'd7;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            take_beats = 1'b0;
    int              sent_count = 0;
    int              gap_style = 0;
    int              stall_style = 0;
    int              stall_left = 0;
    int              quiet_cycles = 0;
    int              table_fill = 0;
    int              mismatches;
    int              beats_due;
    logic [ID_W-1:0] known_ids [$];

    pza_req_if req_if ();
    pza_rsp_if rsp_if ();

    assign rsp_if.ready = take_beats;

    priority_zone_allocator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    pza_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_if),
        .rsp        (rsp_if),
        .fail_count (mismatches),
        .beats_due  (beats_due)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap(input int style);
        int roll;

        roll = $urandom_range(0, 99);
        if (style == 0 || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, (style == 2) ? 50 : 20);
    endfunction

    function automatic logic [MASK_W-1:0] pick_zones();
        int lo;
        int hi;

        case ($urandom_range(0, 5))
            0: return MASK_W'($urandom);
            1: return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
            2:
            begin
                lo = $urandom_range(0, MASK_W - 1);
                hi = $urandom_range(lo, MASK_W - 1);
                return ({MASK_W{1'b1}} >> (MASK_W - 1 - hi + lo)) << lo;
            end
            3: return '1;
            4: return '0;
            default: return MASK_W'($urandom & $urandom & $urandom);
        endcase
    endfunction

    // Small pools make priority ties common
    function automatic logic [PRI_W-1:0] pick_priority();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return PRI_W'(8'h80 + $urandom_range(0, 2));
            default: return PRI_W'($urandom);
        endcase
    endfunction

    // Present one request beat and hold it until it is taken
    task automatic send_request(input logic [TYPE_W-1:0] kind, input logic [ID_W-1:0] id,
                                input logic [PRI_W-1:0] pri,
                                input logic [MASK_W-1:0] zones);
        int gap;

        gap = pick_gap(gap_style);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.req_type     <= kind;
        req_if.effect_id    <= id;
        req_if.priority_req <= pri;
        req_if.zone_mask    <= zones;
        do
            @(posedge clk);
        while (!req_if.ready);
        sent_count++;
    endtask

    // Back-pressure on the result channel
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            take_beats <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stall_style != 0 && $urandom_range(0, 3) == 0)
        begin
            take_beats <= 1'b0;
            stall_left <= pick_gap(stall_style);
        end
        else
            take_beats <= 1'b1;
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("priority_zone_allocator_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        int              adds;
        int              pick;
        logic [ID_W-1:0] id;

        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.req_type     = '0;
        req_if.effect_id    = '0;
        req_if.priority_req = '0;
        req_if.zone_mask    = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        gap_style   = 1;
        stall_style = 1;
        send_request(REQ_FRAME, 8'h00, 8'h00, 32'h0);             // empty frame
        send_request(REQ_QUERY, 8'hFF, 8'hFF, 32'hFFFF_FFFF);     // empty query
        send_request(REQ_REGISTER, 8'h00, 8'h00, 32'h0000_0000);
        send_request(REQ_REGISTER, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_request(REQ_REGISTER, 8'h12, 8'hFF, 32'h0000_FFFF);  // tie, goes after
        send_request(REQ_REGISTER, 8'h12, 8'h80, 32'hF0F0_F0F0);  // duplicate id
        send_request(REQ_REGISTER, 8'h5A, 8'h80, 32'h0000_0001);
        send_request(REQ_ACTIVATE, 8'h12, 8'h00, 32'h0);
        send_request(REQ_ACTIVATE, 8'hFF, 8'h00, 32'h0);
        send_request(REQ_ACTIVATE, 8'h00, 8'h00, 32'h0);
        send_request(REQ_ACTIVATE, 8'h77, 8'h00, 32'h0);          // unknown id
        send_request(REQ_ACTIVATE, 8'h12, 8'h00, 32'h0);          // first already active
        send_request(REQ_FRAME, 8'h00, 8'h00, 32'h0);             // all but one shadowed
        send_request(REQ_FRAME, 8'h00, 8'h00, 32'h0);             // shadowed stay shadowed
        send_request(REQ_DEACTIVATE, 8'hFF, 8'h00, 32'h0);
        send_request(REQ_ACTIVATE, 8'h5A, 8'h00, 32'h0);
        send_request(REQ_FRAME, 8'h00, 8'h00, 32'h0);             // shadowed back to active
        send_request(REQ_QUERY, 8'h00, 8'h00, 32'h0);
        send_request(REQ_DEACTIVATE, 8'h12, 8'h00, 32'h0);
        send_request(REQ_DEACTIVATE, 8'h12, 8'h00, 32'h0);        // first already idle
        send_request(REQ_SPARE_LO, 8'h00, 8'h00, 32'h0);
        send_request(REQ_SPARE_HI, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_request(REQ_CLEAR, 8'h00, 8'h00, 32'h0);
        send_request(REQ_QUERY, 8'h00, 8'h00, 32'h0);             // empty after clear

        // Random part: fill the table, then mix state changes with listings
        while (sent_count < ITEM_TARGET)
        begin
            gap_style   = $urandom_range(0, 2);
            stall_style = $urandom_range(0, 2);
            if (table_fill >= MAX_ENTRIES_DEF || $urandom_range(0, 4) == 0)
            begin
                send_request(REQ_CLEAR, ID_W'($urandom), PRI_W'($urandom), MASK_W'($urandom));
                known_ids.delete();
                table_fill = 0;
            end

            // Now and then overfill the table
            adds = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 36) : $urandom_range(1, 5);
            repeat (adds)
            begin
                id = ($urandom_range(0, 1) == 0) ? ID_POOL + ID_W'($urandom_range(0, 7))
                                                 : ID_W'($urandom);
                send_request(REQ_REGISTER, id, pick_priority(), pick_zones());
                if (table_fill < MAX_ENTRIES_DEF)
                begin
                    table_fill++;
                    known_ids.push_back(id);
                end
            end

            repeat ($urandom_range(3, 12))
            begin
                pick = $urandom_range(0, 99);
                if (known_ids.size() != 0 && $urandom_range(0, 6) != 0)
                    id = known_ids[$urandom_range(0, known_ids.size() - 1)];
                else
                    id = ID_W'($urandom);
                if (pick < 35)
                    send_request(REQ_ACTIVATE, id, PRI_W'($urandom), MASK_W'($urandom));
                else if (pick < 50)
                    send_request(REQ_DEACTIVATE, id, PRI_W'($urandom), MASK_W'($urandom));
                else if (pick < 78)
                    send_request(REQ_FRAME, id, PRI_W'($urandom), MASK_W'($urandom));
                else if (pick < 92)
                    send_request(REQ_QUERY, id, PRI_W'($urandom), MASK_W'($urandom));
                else
                    send_request(pick[0] ? REQ_SPARE_HI : REQ_SPARE_LO, id,
                                 pick_priority(), pick_zones());
            end
        end

        // Drain: wait for every due beat, then a tail for stray beats
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (beats_due != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && beats_due == 0)
            $display("priority_zone_allocator_tb: PASS");
        else
            $display("priority_zone_allocator_tb: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/pza_pkg.sv
rtl/core/pza_ifs.sv
rtl/core/pza_dpath.sv
rtl/core/pza_ctrl.sv
rtl/core/priority_zone_allocator.sv
verif/pza_checker.sv
verif/priority_zone_allocator_tb.sv
